// ----- design/gpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpdc_pkg: shared types, tables and helpers for the date converter
// Holds the field widths, the operation and status codes, the calendar
// threshold tables and the small arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package gpdc_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OYEAR_W = 13;
	localparam int DOY_W   = 9;
	localparam int SECT_W  = 4;
	localparam int HY_W    = 7;

	// Operation and status codes
	localparam logic OP_G2P     = 1'b0;
	localparam logic OP_P2G     = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam int NUM_MONTHS = 12;
	localparam int CENTURY    = 100;
	localparam int QUAD_CENT  = 400;

	// Year offsets and bases
	localparam int YEAR_OFS_EARLY = 622;
	localparam int YEAR_OFS_LATE  = 621;
	localparam int GREG_BASE      = 2000;
	localparam int P2G_STEP_EARLY = 21;
	localparam int P2G_STEP_LATE  = 22;

	// Last section that still belongs to the earlier year
	localparam int G2P_LAST_EARLY = 2;
	localparam int P2G_LAST_EARLY = 9;

	// Day offsets used when the day of year falls in the first section
	localparam int G2P_FIRST_OFS = 30;
	localparam int P2G_FIRST_OFS = 31;

	localparam int P_LAST_LONG   = 346;
	localparam int P_ESFAND_LONG = 30;

	// Reciprocal of 100 for 12-bit years: floor(y*41/4096) is y/100 or one more
	localparam int RECIP_100   = 41;
	localparam int RECIP_SHIFT = 12;
	localparam int RECIP_Q_W   = 6;
	localparam int RECIP_P_W   = YEAR_W + RECIP_Q_W;

	typedef logic [DOY_W-1:0]   doy_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [SECT_W-1:0]  sect_t;
	typedef doy_t   len_tab_t [NUM_MONTHS];
	typedef month_t mon_tab_t [NUM_MONTHS+1];
	typedef day_t   mlen_tab_t [NUM_MONTHS];

	localparam len_tab_t G2P_LEN = '{9'd20, 9'd50, 9'd79, 9'd110, 9'd141, 9'd172,
		9'd203, 9'd234, 9'd265, 9'd295, 9'd325, 9'd355};
	localparam len_tab_t P2G_LEN = '{9'd11, 9'd41, 9'd72, 9'd102, 9'd133, 9'd164,
		9'd194, 9'd225, 9'd255, 9'd286, 9'd317, 9'd345};
	localparam mon_tab_t G2P_MON = '{4'd10, 4'd11, 4'd12, 4'd1, 4'd2, 4'd3, 4'd4,
		4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10};
	localparam mon_tab_t P2G_MON = '{4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
		4'd10, 4'd11, 4'd12, 4'd1, 4'd2, 4'd3};
	localparam mlen_tab_t P_MLEN = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
		5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd29};
	localparam mlen_tab_t G_MLEN = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
	// Days before the first of each month (common year / Persian year)
	localparam len_tab_t G_CUM = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
	localparam len_tab_t P_CUM = '{9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155,
		9'd186, 9'd216, 9'd246, 9'd276, 9'd306, 9'd336};

	localparam month_t MONTH_FEB = 4'd2;
	localparam month_t MONTH_DEC = 4'd12;

	typedef struct packed {
		logic                operation;
		logic [YEAR_W-1:0]   in_year;
		month_t              in_month;
		day_t                in_day;
	} date_req_t;

	typedef struct packed {
		logic signed [OYEAR_W-1:0] out_year;
		month_t                    out_month;
		day_t                      out_day;
		logic                      status;
	} date_rsp_t;

	// Multiple of 100: one compare per century in the year range
	function automatic logic is_century(input logic [YEAR_W-1:0] year);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k <= ((1 << YEAR_W) - 1) / CENTURY; k++) begin
			if (year == YEAR_W'(k * CENTURY)) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic is_quad_century(input logic [YEAR_W-1:0] year);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k <= ((1 << YEAR_W) - 1) / QUAD_CENT; k++) begin
			if (year == YEAR_W'(k * QUAD_CENT)) hit = 1'b1;
		end
		return hit;
	endfunction

	// year mod 100 by reciprocal multiply and a single correction
	function automatic logic [HY_W-1:0] year_mod100(input logic [YEAR_W-1:0] year);
		logic [RECIP_P_W-1:0] prod;
		logic [RECIP_Q_W-1:0] q;
		logic [YEAR_W:0]      p;
		logic [YEAR_W:0]      r;
		prod = RECIP_P_W'(year) * RECIP_P_W'(RECIP_100);
		q    = prod[RECIP_SHIFT +: RECIP_Q_W];
		p    = (YEAR_W+1)'(q) * (YEAR_W+1)'(CENTURY);
		if (p > (YEAR_W+1)'(year)) p = p - (YEAR_W+1)'(CENTURY);
		r = (YEAR_W+1)'(year) - p;
		return r[HY_W-1:0];
	endfunction

	// Index of the first threshold not below doy; NUM_MONTHS when past all
	function automatic sect_t find_section(input doy_t doy, input len_tab_t tab);
		sect_t s;
		s = SECT_W'(NUM_MONTHS);
		for (int i = NUM_MONTHS - 1; i >= 0; i--) begin
			if (doy <= tab[i]) s = SECT_W'(i);
		end
		return s;
	endfunction

endpackage

// ----- design/gpdc_req_if.sv -----
// ----------------------------------------------------------------------------
// gpdc_req_if: request channel of the date converter
// Valid/ready channel carrying one date and the conversion direction.
// ----------------------------------------------------------------------------
interface gpdc_req_if import gpdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [YEAR_W-1:0] in_year;
	month_t            in_month;
	day_t              in_day;

	modport source (output valid, output operation, output in_year, output in_month,
		output in_day, input ready);
	modport sink (input valid, input operation, input in_year, input in_month,
		input in_day, output ready);
endinterface

// ----- design/gpdc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gpdc_rsp_if: result channel of the date converter
// Valid/ready channel carrying one converted date and its status.
// ----------------------------------------------------------------------------
interface gpdc_rsp_if import gpdc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [OYEAR_W-1:0] out_year;
	month_t                    out_month;
	day_t                      out_day;
	logic                      status;

	modport source (output valid, output out_year, output out_month, output out_day,
		output status, input ready);
	modport sink (input valid, input out_year, input out_month, input out_day,
		input status, output ready);
endinterface

// ----- design/gregorian_persian_date_convert_top.sv -----
// ----------------------------------------------------------------------------
// gregorian_persian_date_convert_top: Gregorian / Persian date converter
// Converts one date per item in either direction, flagging bad dates.
// ----------------------------------------------------------------------------
// Usage:
//   date_req  (sink)   : operation selects the direction (OP_G2P / OP_P2G),
//                        in_year / in_month / in_day give the source date.
//   date_rsp  (source) : out_year / out_month / out_day and status. A bad
//                        month or day gives STATUS_BAD with the input echoed.
//   An item moves on a rising clk edge with valid and ready both high.
// Path: the item is held in the input register (_s1), the conversion runs
//   combinationally, and the result is captured in the output register
//   (_s2), which drives date_rsp.valid.
// Throughput: one item per cycle while date_rsp is taken, set by the
//   single-pass conversion logic between the two registers.
// Stall: while date_rsp is not taken, the output register holds its item and
//   the input register can still take one more item, so up to two items wait
//   inside the block before date_req.ready drops.
// Reset: arst_n low clears both valid flags at once; no item is in flight.
// ----------------------------------------------------------------------------
module gregorian_persian_date_convert_top import gpdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gpdc_req_if.sink    date_req,
	gpdc_rsp_if.source  date_rsp
);

	// Pipeline registers
	date_req_t req_s1;
	logic      vld_s1;
	date_rsp_t rsp_s2;
	logic      vld_s2;
	logic      adv;

	// Shared decode
	logic              month_ok;
	month_t            m_idx;
	logic [YEAR_W-1:0] year;
	day_t              day;

	// Gregorian to Persian
	logic         leap;
	day_t         g_mlen;
	logic         g_day_ok;
	doy_t         g_doy;
	len_tab_t     g_len;
	sect_t        g_sect;
	logic [DOY_W:0] g_rd;
	logic [OYEAR_W-1:0] g_year;

	// Persian to Gregorian
	logic [HY_W-1:0] hy;
	logic            pre;
	day_t            p_mlen;
	logic            p_day_ok;
	doy_t            p_doy;
	len_tab_t        p_len;
	sect_t           p_sect;
	logic [DOY_W:0]  p_rd;
	logic [HY_W:0]   p_y2;
	logic [HY_W:0]   p_hy2;
	logic [OYEAR_W-1:0] p_year;

	date_rsp_t rsp_d;

	// Advance the output stage when it is empty or being taken
	assign adv           = !vld_s2 || date_rsp.ready;
	assign date_req.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (date_req.ready) begin
			vld_s1 <= date_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (date_req.ready && date_req.valid) begin
			req_s1.operation <= date_req.operation;
			req_s1.in_year   <= date_req.in_year;
			req_s1.in_month  <= date_req.in_month;
			req_s1.in_day    <= date_req.in_day;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	// Shared decode of the held item
	assign year     = req_s1.in_year;
	assign day      = req_s1.in_day;
	assign month_ok = (req_s1.in_month >= 4'd1) && (req_s1.in_month <= MONTH_W'(NUM_MONTHS));
	assign m_idx    = month_ok ? (req_s1.in_month - 4'd1) : '0;

	// Gregorian to Persian: day of year, then threshold search
	assign leap = ((year[1:0] == 2'b00) && !is_century(year)) || is_quad_century(year);

	always_comb begin
		g_mlen = G_MLEN[m_idx];
		if (leap && (req_s1.in_month == MONTH_FEB)) g_mlen = g_mlen + 5'd1;
	end

	assign g_day_ok = (day != '0) && (day <= g_mlen);
	assign g_doy    = G_CUM[m_idx] + DOY_W'(day)
		+ DOY_W'(leap && (req_s1.in_month > MONTH_FEB));

	// Year just after a multiple of four: first two thresholds drop by one
	always_comb begin
		g_len = G2P_LEN;
		if (year[1:0] == 2'b01) begin
			g_len[0] = G2P_LEN[0] - 9'd1;
			g_len[1] = G2P_LEN[1] - 9'd1;
		end
	end

	assign g_sect = find_section(g_doy, g_len);

	always_comb begin
		if (g_sect == '0) begin
			g_rd = (DOY_W+1)'(g_doy) + (DOY_W+1)'(G2P_FIRST_OFS) - (DOY_W+1)'(g_len[0]);
		end else begin
			g_rd = (DOY_W+1)'(g_doy) - (DOY_W+1)'(g_len[g_sect - 4'd1]);
		end
	end

	assign g_year = {1'b0, year} - ((g_sect <= SECT_W'(G2P_LAST_EARLY)) ?
		OYEAR_W'(YEAR_OFS_EARLY) : OYEAR_W'(YEAR_OFS_LATE));

	// Persian to Gregorian: year within the century picks the table variant
	assign hy  = year_mod100(year);
	assign pre = (hy[1:0] == 2'b11);

	// Last month is long in the leap slot and also accepts day 30 just before it
	always_comb begin
		p_mlen = P_MLEN[m_idx];
		if ((req_s1.in_month == MONTH_DEC) && ((hy[1:0] == 2'b00) || pre)) begin
			p_mlen = DAY_W'(P_ESFAND_LONG);
		end
	end

	assign p_day_ok = (day != '0) && (day <= p_mlen);
	assign p_doy    = P_CUM[m_idx] + DOY_W'(day);

	always_comb begin
		for (int i = 0; i < NUM_MONTHS; i++) begin
			p_len[i] = P2G_LEN[i] + DOY_W'(pre);
		end
		if (hy[1:0] == 2'b10) p_len[NUM_MONTHS-1] = DOY_W'(P_LAST_LONG);
	end

	assign p_sect = find_section(p_doy, p_len);

	always_comb begin
		if (p_sect == '0) begin
			p_rd = (DOY_W+1)'(p_doy) + (DOY_W+1)'(P2G_FIRST_OFS) - (DOY_W+1)'(p_len[0]);
		end else begin
			p_rd = (DOY_W+1)'(p_doy) - (DOY_W+1)'(p_len[p_sect - 4'd1]);
		end
	end

	// Wrap the two-digit year within the century
	assign p_y2  = (HY_W+1)'(hy) + ((p_sect <= SECT_W'(P2G_LAST_EARLY)) ?
		(HY_W+1)'(P2G_STEP_EARLY) : (HY_W+1)'(P2G_STEP_LATE));
	assign p_hy2 = (p_y2 >= (HY_W+1)'(CENTURY)) ? (p_y2 - (HY_W+1)'(CENTURY)) : p_y2;
	assign p_year = OYEAR_W'(p_hy2) + OYEAR_W'(GREG_BASE);

	// Select direction, or echo the input on a bad date
	always_comb begin
		rsp_d.out_year  = $signed({1'b0, year});
		rsp_d.out_month = req_s1.in_month;
		rsp_d.out_day   = day;
		rsp_d.status    = STATUS_BAD;
		if (month_ok) begin
			unique case (req_s1.operation)
				OP_G2P: begin
					if (g_day_ok) begin
						rsp_d.out_year  = $signed(g_year);
						rsp_d.out_month = G2P_MON[g_sect];
						rsp_d.out_day   = g_rd[DAY_W-1:0];
						rsp_d.status    = STATUS_OK;
					end
				end
				OP_P2G: begin
					if (p_day_ok) begin
						rsp_d.out_year  = $signed(p_year);
						rsp_d.out_month = P2G_MON[p_sect];
						rsp_d.out_day   = p_rd[DAY_W-1:0];
						rsp_d.status    = STATUS_OK;
					end
				end
				default: begin
					rsp_d.status = STATUS_BAD;
				end
			endcase
		end
	end

	assign date_rsp.valid     = vld_s2;
	assign date_rsp.out_year  = rsp_s2.out_year;
	assign date_rsp.out_month = rsp_s2.out_month;
	assign date_rsp.out_day   = rsp_s2.out_day;
	assign date_rsp.status    = rsp_s2.status;

	// A converted item always carries a real month
	a_ok_month: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (rsp_s2.status == STATUS_OK)) |->
		((rsp_s2.out_month >= 4'd1) && (rsp_s2.out_month <= MONTH_W'(NUM_MONTHS))))
		else $error("converted item with month out of range");

	// A converted item never has day zero
	a_ok_day: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (rsp_s2.status == STATUS_OK)) |-> (rsp_s2.out_day != '0))
		else $error("converted item with day zero");

	// A held item in the input register is not lost while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(req_s1)))
		else $error("input register dropped a stalled item");

	// An echoed item carries a nonnegative year
	a_echo_year: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (rsp_s2.status == STATUS_BAD)) |-> !rsp_s2.out_year[OYEAR_W-1])
		else $error("echoed item with negative year");

endmodule
